FILE: rtl/mipb_pkg.sv
`default_nettype none
// Package for the modular interval preimage bounds unit.
// Holds the datapath widths, the microcode operation and register codes and the microcode ROM.
// It depends on nothing else.
package mipb_pkg;

  localparam int DW = 80;
  localparam int FW = 32;
  localparam int MW = 33;
  localparam int PCW = 8;
  localparam int RAW = 6;
  localparam int RF_DEPTH = 40;
  localparam int CW = 7;

  localparam logic [3:0] OP_CONST = 4'd0;
  localparam logic [3:0] OP_LDIN  = 4'd1;
  localparam logic [3:0] OP_ADD   = 4'd2;
  localparam logic [3:0] OP_SUB   = 4'd3;
  localparam logic [3:0] OP_MUL   = 4'd4;
  localparam logic [3:0] OP_FDIV  = 4'd5;
  localparam logic [3:0] OP_CDIV  = 4'd6;
  localparam logic [3:0] OP_MOD   = 4'd7;
  localparam logic [3:0] OP_BEQ   = 4'd8;
  localparam logic [3:0] OP_BNE   = 4'd9;
  localparam logic [3:0] OP_BLT   = 4'd10;
  localparam logic [3:0] OP_BLE   = 4'd11;
  localparam logic [3:0] OP_JMP   = 4'd12;
  localparam logic [3:0] OP_CALL  = 4'd13;
  localparam logic [3:0] OP_RET   = 4'd14;
  localparam logic [3:0] OP_DONE  = 4'd15;

  localparam logic [PCW-1:0] SEL_MOD  = 8'd0;
  localparam logic [PCW-1:0] SEL_SEED = 8'd1;
  localparam logic [PCW-1:0] SEL_COEF = 8'd2;
  localparam logic [PCW-1:0] SEL_LO   = 8'd3;
  localparam logic [PCW-1:0] SEL_HI   = 8'd4;

  localparam logic [RAW-1:0] R_ZERO  = 6'd0;
  localparam logic [RAW-1:0] R_ONE   = 6'd1;
  localparam logic [RAW-1:0] R_CAP   = 6'd2;
  localparam logic [RAW-1:0] R_M     = 6'd3;
  localparam logic [RAW-1:0] R_Y0    = 6'd4;
  localparam logic [RAW-1:0] R_A     = 6'd5;
  localparam logic [RAW-1:0] R_LO    = 6'd6;
  localparam logic [RAW-1:0] R_HI    = 6'd7;
  localparam logic [RAW-1:0] R_MM1   = 6'd8;
  localparam logic [RAW-1:0] R_T0    = 6'd9;
  localparam logic [RAW-1:0] R_T1    = 6'd10;
  localparam logic [RAW-1:0] R_T2    = 6'd11;
  localparam logic [RAW-1:0] R_AY    = 6'd12;
  localparam logic [RAW-1:0] R_AOK   = 6'd13;
  localparam logic [RAW-1:0] R_LIM   = 6'd14;
  localparam logic [RAW-1:0] R_YMAX  = 6'd15;
  localparam logic [RAW-1:0] R_YMIN  = 6'd16;
  localparam logic [RAW-1:0] R_CNT   = 6'd17;
  localparam logic [RAW-1:0] R_NHI   = 6'd18;
  localparam logic [RAW-1:0] R_NLO   = 6'd19;
  localparam logic [RAW-1:0] R_RY    = 6'd20;
  localparam logic [RAW-1:0] R_RLO   = 6'd21;
  localparam logic [RAW-1:0] R_RHI   = 6'd22;
  localparam logic [RAW-1:0] R_RR    = 6'd23;
  localparam logic [RAW-1:0] R_L     = 6'd24;
  localparam logic [RAW-1:0] R_AM    = 6'd25;
  localparam logic [RAW-1:0] R_P     = 6'd26;
  localparam logic [RAW-1:0] R_X     = 6'd27;
  localparam logic [RAW-1:0] R_D     = 6'd28;
  localparam logic [RAW-1:0] R_YH0   = 6'd29;
  localparam logic [RAW-1:0] R_YL1   = 6'd30;
  localparam logic [RAW-1:0] R_Q     = 6'd31;
  localparam logic [RAW-1:0] R_YH1   = 6'd32;
  localparam logic [RAW-1:0] R_AYH1  = 6'd33;
  localparam logic [RAW-1:0] R_STEP  = 6'd34;
  localparam logic [RAW-1:0] R_ALPHA = 6'd35;
  localparam logic [RAW-1:0] R_YHN   = 6'd36;
  localparam logic [RAW-1:0] R_AYHN  = 6'd37;
  localparam logic [RAW-1:0] R_YNX   = 6'd38;
  localparam logic [RAW-1:0] R_AYNX  = 6'd39;

  localparam logic [PCW-1:0] L_FULL  = 8'd72;
  localparam logic [PCW-1:0] L_FAIL  = 8'd73;
  localparam logic [PCW-1:0] L_ALLOW = 8'd74;
  localparam logic [PCW-1:0] L_RIGHT = 8'd85;
  localparam logic [PCW-1:0] L_RYH0  = 8'd134;
  localparam logic [PCW-1:0] L_RYH1  = 8'd136;
  localparam logic [PCW-1:0] L_RYHN  = 8'd138;

  typedef struct packed {
    logic [3:0]     op;
    logic [RAW-1:0] dst;
    logic [RAW-1:0] a;
    logic [RAW-1:0] b;
    logic [PCW-1:0] imm;
  } instr_t;

  function automatic instr_t mk(input logic [3:0] op, input logic [RAW-1:0] d,
                                input logic [RAW-1:0] a, input logic [RAW-1:0] b,
                                input logic [PCW-1:0] imm);
    instr_t r;
    r.op = op;
    r.dst = d;
    r.a = a;
    r.b = b;
    r.imm = imm;
    return r;
  endfunction

  function automatic instr_t rom(input logic [PCW-1:0] pc);
    instr_t r;
    r = mk(OP_DONE, R_ZERO, R_ZERO, R_ZERO, 8'd0);
    case (pc)
      8'd0:   r = mk(OP_CONST, R_ZERO, R_ZERO, R_ZERO, 8'd0);
      8'd1:   r = mk(OP_CONST, R_ONE, R_ZERO, R_ZERO, 8'd1);
      8'd2:   r = mk(OP_CONST, R_CAP, R_ZERO, R_ZERO, 8'd100);
      8'd3:   r = mk(OP_LDIN, R_M, R_ZERO, R_ZERO, SEL_MOD);
      8'd4:   r = mk(OP_LDIN, R_T0, R_ZERO, R_ZERO, SEL_SEED);
      8'd5:   r = mk(OP_MOD, R_Y0, R_T0, R_M, 8'd0);
      8'd6:   r = mk(OP_LDIN, R_T0, R_ZERO, R_ZERO, SEL_COEF);
      8'd7:   r = mk(OP_MOD, R_A, R_T0, R_M, 8'd0);
      8'd8:   r = mk(OP_LDIN, R_T0, R_ZERO, R_ZERO, SEL_LO);
      8'd9:   r = mk(OP_MOD, R_LO, R_T0, R_M, 8'd0);
      8'd10:  r = mk(OP_LDIN, R_T0, R_ZERO, R_ZERO, SEL_HI);
      8'd11:  r = mk(OP_MOD, R_HI, R_T0, R_M, 8'd0);
      8'd12:  r = mk(OP_SUB, R_MM1, R_M, R_ONE, 8'd0);
      8'd13:  r = mk(OP_ADD, R_AY, R_Y0, R_ZERO, 8'd0);
      8'd14:  r = mk(OP_CALL, R_ZERO, R_ZERO, R_ZERO, L_ALLOW);
      8'd15:  r = mk(OP_BEQ, R_ZERO, R_AOK, R_ZERO, L_FAIL);
      8'd16:  r = mk(OP_BLT, R_ZERO, R_HI, R_LO, 8'd20);
      8'd17:  r = mk(OP_BNE, R_ZERO, R_LO, R_ZERO, 8'd22);
      8'd18:  r = mk(OP_BEQ, R_ZERO, R_HI, R_MM1, L_FULL);
      8'd19:  r = mk(OP_JMP, R_ZERO, R_ZERO, R_ZERO, 8'd22);
      8'd20:  r = mk(OP_ADD, R_T0, R_HI, R_ONE, 8'd0);
      8'd21:  r = mk(OP_BEQ, R_ZERO, R_LO, R_T0, L_FULL);
      8'd22:  r = mk(OP_BEQ, R_ZERO, R_A, R_ZERO, L_FULL);
      8'd23:  r = mk(OP_ADD, R_LIM, R_Y0, R_MM1, 8'd0);
      8'd24:  r = mk(OP_ADD, R_RY, R_Y0, R_ZERO, 8'd0);
      8'd25:  r = mk(OP_ADD, R_RLO, R_LO, R_ZERO, 8'd0);
      8'd26:  r = mk(OP_ADD, R_RHI, R_HI, R_ZERO, 8'd0);
      8'd27:  r = mk(OP_CALL, R_ZERO, R_ZERO, R_ZERO, L_RIGHT);
      8'd28:  r = mk(OP_ADD, R_YMAX, R_RR, R_ZERO, 8'd0);
      8'd29:  r = mk(OP_CONST, R_CNT, R_ZERO, R_ZERO, 8'd0);
      8'd30:  r = mk(OP_BLE, R_ZERO, R_LIM, R_YMAX, 8'd39);
      8'd31:  r = mk(OP_ADD, R_AY, R_YMAX, R_ONE, 8'd0);
      8'd32:  r = mk(OP_CALL, R_ZERO, R_ZERO, R_ZERO, L_ALLOW);
      8'd33:  r = mk(OP_BEQ, R_ZERO, R_AOK, R_ZERO, 8'd39);
      8'd34:  r = mk(OP_ADD, R_RY, R_YMAX, R_ONE, 8'd0);
      8'd35:  r = mk(OP_CALL, R_ZERO, R_ZERO, R_ZERO, L_RIGHT);
      8'd36:  r = mk(OP_ADD, R_YMAX, R_RR, R_ZERO, 8'd0);
      8'd37:  r = mk(OP_ADD, R_CNT, R_CNT, R_ONE, 8'd0);
      8'd38:  r = mk(OP_BNE, R_ZERO, R_CNT, R_CAP, 8'd30);
      8'd39:  r = mk(OP_SUB, R_T0, R_YMAX, R_M, 8'd0);
      8'd40:  r = mk(OP_ADD, R_LIM, R_T0, R_ONE, 8'd0);
      8'd41:  r = mk(OP_ADD, R_YMIN, R_Y0, R_ZERO, 8'd0);
      8'd42:  r = mk(OP_CONST, R_CNT, R_ZERO, R_ZERO, 8'd0);
      8'd43:  r = mk(OP_SUB, R_NHI, R_M, R_HI, 8'd0);
      8'd44:  r = mk(OP_BNE, R_ZERO, R_HI, R_ZERO, 8'd46);
      8'd45:  r = mk(OP_ADD, R_NHI, R_ZERO, R_ZERO, 8'd0);
      8'd46:  r = mk(OP_SUB, R_NLO, R_M, R_LO, 8'd0);
      8'd47:  r = mk(OP_BNE, R_ZERO, R_LO, R_ZERO, 8'd49);
      8'd48:  r = mk(OP_ADD, R_NLO, R_ZERO, R_ZERO, 8'd0);
      8'd49:  r = mk(OP_BLE, R_ZERO, R_YMIN, R_LIM, 8'd66);
      8'd50:  r = mk(OP_SUB, R_AY, R_YMIN, R_ONE, 8'd0);
      8'd51:  r = mk(OP_CALL, R_ZERO, R_ZERO, R_ZERO, L_ALLOW);
      8'd52:  r = mk(OP_BEQ, R_ZERO, R_AOK, R_ZERO, 8'd66);
      8'd53:  r = mk(OP_SUB, R_T1, R_YMIN, R_ONE, 8'd0);
      8'd54:  r = mk(OP_SUB, R_RY, R_ZERO, R_T1, 8'd0);
      8'd55:  r = mk(OP_ADD, R_RLO, R_NHI, R_ZERO, 8'd0);
      8'd56:  r = mk(OP_ADD, R_RHI, R_NLO, R_ZERO, 8'd0);
      8'd57:  r = mk(OP_CALL, R_ZERO, R_ZERO, R_ZERO, L_RIGHT);
      8'd58:  r = mk(OP_SUB, R_YMIN, R_ZERO, R_RR, 8'd0);
      8'd59:  r = mk(OP_BLE, R_ZERO, R_YMIN, R_T1, 8'd64);
      8'd60:  r = mk(OP_SUB, R_T0, R_YMIN, R_T1, 8'd0);
      8'd61:  r = mk(OP_CDIV, R_T0, R_T0, R_M, 8'd0);
      8'd62:  r = mk(OP_MUL, R_T0, R_T0, R_M, 8'd0);
      8'd63:  r = mk(OP_SUB, R_YMIN, R_YMIN, R_T0, 8'd0);
      8'd64:  r = mk(OP_ADD, R_CNT, R_CNT, R_ONE, 8'd0);
      8'd65:  r = mk(OP_BNE, R_ZERO, R_CNT, R_CAP, 8'd49);
      8'd66:  r = mk(OP_SUB, R_T0, R_YMAX, R_YMIN, 8'd0);
      8'd67:  r = mk(OP_ADD, R_T0, R_T0, R_ONE, 8'd0);
      8'd68:  r = mk(OP_BLE, R_ZERO, R_M, R_T0, L_FULL);
      8'd69:  r = mk(OP_MOD, R_T0, R_YMIN, R_M, 8'd0);
      8'd70:  r = mk(OP_MOD, R_T1, R_YMAX, R_M, 8'd0);
      8'd71:  r = mk(OP_DONE, R_ZERO, R_T0, R_T1, 8'd1);
      8'd72:  r = mk(OP_DONE, R_ZERO, R_ZERO, R_MM1, 8'd1);
      8'd73:  r = mk(OP_DONE, R_ZERO, R_ZERO, R_ZERO, 8'd0);
      8'd74:  r = mk(OP_MUL, R_T2, R_A, R_AY, 8'd0);
      8'd75:  r = mk(OP_MOD, R_T2, R_T2, R_M, 8'd0);
      8'd76:  r = mk(OP_BLT, R_ZERO, R_HI, R_LO, 8'd81);
      8'd77:  r = mk(OP_BLT, R_ZERO, R_T2, R_LO, 8'd83);
      8'd78:  r = mk(OP_BLT, R_ZERO, R_HI, R_T2, 8'd83);
      8'd79:  r = mk(OP_CONST, R_AOK, R_ZERO, R_ZERO, 8'd1);
      8'd80:  r = mk(OP_RET, R_ZERO, R_ZERO, R_ZERO, 8'd0);
      8'd81:  r = mk(OP_BLE, R_ZERO, R_T2, R_HI, 8'd79);
      8'd82:  r = mk(OP_BLE, R_ZERO, R_LO, R_T2, 8'd79);
      8'd83:  r = mk(OP_CONST, R_AOK, R_ZERO, R_ZERO, 8'd0);
      8'd84:  r = mk(OP_RET, R_ZERO, R_ZERO, R_ZERO, 8'd0);
      8'd85:  r = mk(OP_ADD, R_L, R_RLO, R_ZERO, 8'd0);
      8'd86:  r = mk(OP_BLE, R_ZERO, R_RLO, R_RHI, 8'd88);
      8'd87:  r = mk(OP_SUB, R_L, R_RLO, R_M, 8'd0);
      8'd88:  r = mk(OP_SUB, R_AM, R_A, R_M, 8'd0);
      8'd89:  r = mk(OP_MUL, R_P, R_A, R_RY, 8'd0);
      8'd90:  r = mk(OP_SUB, R_X, R_L, R_P, 8'd0);
      8'd91:  r = mk(OP_CDIV, R_D, R_X, R_M, 8'd0);
      8'd92:  r = mk(OP_MUL, R_X, R_D, R_M, 8'd0);
      8'd93:  r = mk(OP_ADD, R_P, R_P, R_X, 8'd0);
      8'd94:  r = mk(OP_SUB, R_X, R_RHI, R_P, 8'd0);
      8'd95:  r = mk(OP_FDIV, R_D, R_X, R_A, 8'd0);
      8'd96:  r = mk(OP_ADD, R_YH0, R_RY, R_D, 8'd0);
      8'd97:  r = mk(OP_MUL, R_X, R_A, R_D, 8'd0);
      8'd98:  r = mk(OP_ADD, R_P, R_P, R_X, 8'd0);
      8'd99:  r = mk(OP_ADD, R_YL1, R_YH0, R_ONE, 8'd0);
      8'd100: r = mk(OP_ADD, R_Q, R_P, R_AM, 8'd0);
      8'd101: r = mk(OP_BLT, R_ZERO, R_Q, R_L, L_RYH0);
      8'd102: r = mk(OP_BLT, R_ZERO, R_RHI, R_Q, L_RYH0);
      8'd103: r = mk(OP_SUB, R_X, R_RHI, R_Q, 8'd0);
      8'd104: r = mk(OP_FDIV, R_D, R_X, R_A, 8'd0);
      8'd105: r = mk(OP_ADD, R_YH1, R_YL1, R_D, 8'd0);
      8'd106: r = mk(OP_MUL, R_X, R_A, R_D, 8'd0);
      8'd107: r = mk(OP_ADD, R_AYH1, R_Q, R_X, 8'd0);
      8'd108: r = mk(OP_ADD, R_X, R_AYH1, R_AM, 8'd0);
      8'd109: r = mk(OP_BLT, R_ZERO, R_X, R_L, L_RYH1);
      8'd110: r = mk(OP_BLT, R_ZERO, R_RHI, R_X, L_RYH1);
      8'd111: r = mk(OP_SUB, R_STEP, R_YH1, R_YH0, 8'd0);
      8'd112: r = mk(OP_MUL, R_X, R_A, R_STEP, 8'd0);
      8'd113: r = mk(OP_SUB, R_ALPHA, R_X, R_M, 8'd0);
      8'd114: r = mk(OP_BNE, R_ZERO, R_ALPHA, R_ZERO, 8'd117);
      8'd115: r = mk(OP_ADD, R_RR, R_RY, R_M, 8'd0);
      8'd116: r = mk(OP_RET, R_ZERO, R_ZERO, R_ZERO, 8'd0);
      8'd117: r = mk(OP_BLT, R_ZERO, R_ALPHA, R_ZERO, 8'd120);
      8'd118: r = mk(OP_SUB, R_X, R_RHI, R_AYH1, 8'd0);
      8'd119: r = mk(OP_JMP, R_ZERO, R_ZERO, R_ZERO, 8'd121);
      8'd120: r = mk(OP_SUB, R_X, R_L, R_Q, 8'd0);
      8'd121: r = mk(OP_FDIV, R_D, R_X, R_ALPHA, 8'd0);
      8'd122: r = mk(OP_MUL, R_X, R_D, R_STEP, 8'd0);
      8'd123: r = mk(OP_ADD, R_YHN, R_YH1, R_X, 8'd0);
      8'd124: r = mk(OP_MUL, R_X, R_D, R_ALPHA, 8'd0);
      8'd125: r = mk(OP_ADD, R_AYHN, R_AYH1, R_X, 8'd0);
      8'd126: r = mk(OP_ADD, R_YNX, R_YHN, R_ONE, 8'd0);
      8'd127: r = mk(OP_ADD, R_AYNX, R_AYHN, R_AM, 8'd0);
      8'd128: r = mk(OP_BLT, R_ZERO, R_AYNX, R_L, L_RYHN);
      8'd129: r = mk(OP_BLT, R_ZERO, R_RHI, R_AYNX, L_RYHN);
      8'd130: r = mk(OP_SUB, R_X, R_RHI, R_AYNX, 8'd0);
      8'd131: r = mk(OP_FDIV, R_X, R_X, R_A, 8'd0);
      8'd132: r = mk(OP_ADD, R_RR, R_YNX, R_X, 8'd0);
      8'd133: r = mk(OP_RET, R_ZERO, R_ZERO, R_ZERO, 8'd0);
      8'd134: r = mk(OP_ADD, R_RR, R_YH0, R_ZERO, 8'd0);
      8'd135: r = mk(OP_RET, R_ZERO, R_ZERO, R_ZERO, 8'd0);
      8'd136: r = mk(OP_ADD, R_RR, R_YH1, R_ZERO, 8'd0);
      8'd137: r = mk(OP_RET, R_ZERO, R_ZERO, R_ZERO, 8'd0);
      8'd138: r = mk(OP_ADD, R_RR, R_YHN, R_ZERO, 8'd0);
      8'd139: r = mk(OP_RET, R_ZERO, R_ZERO, R_ZERO, 8'd0);
      default: r = mk(OP_DONE, R_ZERO, R_ZERO, R_ZERO, 8'd0);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/modular_interval_preimage_bounds_unit.sv
// Modular interval preimage bounds unit: a microcoded engine with one register file, one
// adder/comparator and one shared shift-add multiplier / restoring divider; uses mipb_pkg.
// Multiply, divide and modulo run on the shared unit, and each side of the bound is refined
// at most 100 times. One word at a time; busy is high until the result strobe on done_o,
// which the receiver cannot stall. Reset clears control and sets M to 2^32.
`default_nettype none
module modular_interval_preimage_bounds_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [mipb_pkg::FW-1:0]   seed_value_i,
  input  wire logic [mipb_pkg::FW-1:0]   coefficient_i,
  input  wire logic [mipb_pkg::FW-1:0]   range_low_i,
  input  wire logic [mipb_pkg::FW-1:0]   range_high_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [mipb_pkg::MW-1:0]   cfg_wdata_i,
  output logic                           done_o,
  output logic [mipb_pkg::FW-1:0]        bound_min_o,
  output logic [mipb_pkg::FW-1:0]        bound_max_o,
  output logic                           seed_ok_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_UNIT  = 3'd3;
  localparam logic [2:0] ST_WB    = 3'd4;

  localparam int DW = mipb_pkg::DW;
  localparam logic [mipb_pkg::MW-1:0] MOD_MAX = {1'b1, {(mipb_pkg::MW-1){1'b0}}};
  localparam logic [mipb_pkg::MW-1:0] MOD_MIN = mipb_pkg::MW'(2);

  logic [2:0]                   state_q;
  logic [mipb_pkg::PCW-1:0]     pc_q, ret_q;
  logic [mipb_pkg::CW-1:0]      cnt_q;
  logic                         done_q;
  logic [mipb_pkg::MW-1:0]      mod_q;

  logic [mipb_pkg::FW-1:0]      seed_q, coef_q, lo_q, hi_q;
  logic [mipb_pkg::FW-1:0]      bmin_q, bmax_q;
  logic                         ok_q;
  logic [DW-1:0]                rda_q, rdb_q;
  logic [DW-1:0]                uacc_q, ux_q, uy_q;
  logic                         neg_q, dneg_q;
  logic [DW-1:0]                rf_q [mipb_pkg::RF_DEPTH];

  mipb_pkg::instr_t             ins;
  logic [mipb_pkg::PCW-1:0]     pc_inc;
  logic                         lt, eq, take;
  logic                         rf_we;
  logic [DW-1:0]                rf_wd;
  logic [DW-1:0]                dv, rem_sh, qf, unit_res;
  logic                         nz, ge;

  assign ins    = mipb_pkg::rom(pc_q);
  assign pc_inc = pc_q + 1'b1;
  assign lt     = $signed(rda_q) < $signed(rdb_q);
  assign eq     = rda_q == rdb_q;
  assign busy   = state_q != ST_IDLE;

  always_comb begin
    case (ins.op)
      mipb_pkg::OP_BEQ: take = eq;
      mipb_pkg::OP_BNE: take = !eq;
      mipb_pkg::OP_BLT: take = lt;
      mipb_pkg::OP_BLE: take = lt || eq;
      default:          take = 1'b0;
    endcase
  end

  // Dividend of the divider; a ceiling division runs as a floor division of the negation.
  assign dv     = (ins.op == mipb_pkg::OP_CDIV) ? (~rda_q + 1'b1) : rda_q;
  assign rem_sh = {uacc_q[DW-2:0], ux_q[DW-1]};
  assign ge     = rem_sh >= uy_q;
  assign nz     = uacc_q != '0;
  assign qf     = neg_q ? (nz ? ~ux_q : (~ux_q + 1'b1)) : ux_q;

  always_comb begin
    case (ins.op)
      mipb_pkg::OP_MUL:  unit_res = uacc_q;
      mipb_pkg::OP_FDIV: unit_res = qf;
      mipb_pkg::OP_CDIV: unit_res = ~qf + 1'b1;
      mipb_pkg::OP_MOD:  unit_res = (dneg_q && nz) ? (rdb_q - uacc_q) : uacc_q;
      default:           unit_res = uacc_q;
    endcase
  end

  always_comb begin
    rf_we = 1'b0;
    rf_wd = rda_q + rdb_q;
    if (state_q == ST_WB) begin
      rf_we = 1'b1;
      rf_wd = unit_res;
    end else if (state_q == ST_EXEC) begin
      case (ins.op)
        mipb_pkg::OP_CONST: begin
          rf_we = 1'b1;
          rf_wd = DW'(ins.imm);
        end
        mipb_pkg::OP_LDIN: begin
          rf_we = 1'b1;
          case (ins.imm)
            mipb_pkg::SEL_MOD:  rf_wd = DW'(mod_q);
            mipb_pkg::SEL_SEED: rf_wd = DW'(seed_q);
            mipb_pkg::SEL_COEF: rf_wd = DW'(coef_q);
            mipb_pkg::SEL_LO:   rf_wd = DW'(lo_q);
            mipb_pkg::SEL_HI:   rf_wd = DW'(hi_q);
            default:            rf_wd = '0;
          endcase
        end
        mipb_pkg::OP_ADD: begin
          rf_we = 1'b1;
          rf_wd = rda_q + rdb_q;
        end
        mipb_pkg::OP_SUB: begin
          rf_we = 1'b1;
          rf_wd = rda_q - rdb_q;
        end
        default: rf_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_q[ins.dst] <= rf_wd;
    end
    if (state_q == ST_FETCH) begin
      rda_q <= rf_q[ins.a];
      rdb_q <= rf_q[ins.b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= '0;
      ret_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      mod_q   <= MOD_MAX;
    end else begin
      done_q <= (state_q == ST_EXEC) && (ins.op == mipb_pkg::OP_DONE);
      if (cfg_we_i) begin
        if (cfg_wdata_i < MOD_MIN) begin
          mod_q <= MOD_MIN;
        end else if (cfg_wdata_i > MOD_MAX) begin
          mod_q <= MOD_MAX;
        end else begin
          mod_q <= cfg_wdata_i;
        end
      end
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            pc_q    <= '0;
            state_q <= ST_FETCH;
          end
        end
        ST_FETCH: state_q <= ST_EXEC;
        ST_EXEC: begin
          case (ins.op)
            mipb_pkg::OP_MUL, mipb_pkg::OP_FDIV, mipb_pkg::OP_CDIV, mipb_pkg::OP_MOD: begin
              cnt_q   <= '0;
              state_q <= ST_UNIT;
            end
            mipb_pkg::OP_BEQ, mipb_pkg::OP_BNE, mipb_pkg::OP_BLT, mipb_pkg::OP_BLE: begin
              pc_q    <= take ? ins.imm : pc_inc;
              state_q <= ST_FETCH;
            end
            mipb_pkg::OP_JMP: begin
              pc_q    <= ins.imm;
              state_q <= ST_FETCH;
            end
            mipb_pkg::OP_CALL: begin
              ret_q   <= pc_inc;
              pc_q    <= ins.imm;
              state_q <= ST_FETCH;
            end
            mipb_pkg::OP_RET: begin
              pc_q    <= ret_q;
              state_q <= ST_FETCH;
            end
            mipb_pkg::OP_DONE: begin
              state_q <= ST_IDLE;
            end
            default: begin
              pc_q    <= pc_inc;
              state_q <= ST_FETCH;
            end
          endcase
        end
        ST_UNIT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == mipb_pkg::CW'(DW - 1)) begin
            state_q <= ST_WB;
          end
        end
        ST_WB: begin
          pc_q    <= pc_inc;
          state_q <= ST_FETCH;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      seed_q <= seed_value_i;
      coef_q <= coefficient_i;
      lo_q   <= range_low_i;
      hi_q   <= range_high_i;
    end
    if (state_q == ST_EXEC) begin
      if (ins.op == mipb_pkg::OP_MUL) begin
        uacc_q <= '0;
        ux_q   <= rda_q;
        uy_q   <= rdb_q;
      end else begin
        uacc_q <= '0;
        ux_q   <= dv[DW-1] ? (~dv + 1'b1) : dv;
        uy_q   <= rdb_q[DW-1] ? (~rdb_q + 1'b1) : rdb_q;
        dneg_q <= dv[DW-1];
        neg_q  <= dv[DW-1] ^ rdb_q[DW-1];
      end
      if (ins.op == mipb_pkg::OP_DONE) begin
        bmin_q <= rda_q[mipb_pkg::FW-1:0];
        bmax_q <= rdb_q[mipb_pkg::FW-1:0];
        ok_q   <= ins.imm[0];
      end
    end
    if (state_q == ST_UNIT) begin
      if (ins.op == mipb_pkg::OP_MUL) begin
        uacc_q <= uy_q[0] ? (uacc_q + ux_q) : uacc_q;
        ux_q   <= {ux_q[DW-2:0], 1'b0};
        uy_q   <= {1'b0, uy_q[DW-1:1]};
      end else begin
        uacc_q <= ge ? (rem_sh - uy_q) : rem_sh;
        ux_q   <= {ux_q[DW-2:0], ge};
      end
    end
  end

  assign done_o      = done_q;
  assign bound_min_o = bmin_q;
  assign bound_max_o = bmax_q;
  assign seed_ok_o   = ok_q;

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result word shown while busy");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted word did not start work");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_unit_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UNIT) |-> (ins.op == mipb_pkg::OP_MUL || ins.op == mipb_pkg::OP_FDIV ||
                              ins.op == mipb_pkg::OP_CDIV || ins.op == mipb_pkg::OP_MOD))
    else $error("shared unit running for a non-unit operation");
`endif

endmodule
`default_nettype wire

FILE: test/bounds_checker.sv
`timescale 1ns / 100ps
// Checker for the modular interval preimage bounds unit: watches the word and result ports,
// predicts each result in wide signed arithmetic and compares it. Depends on mipb_pkg.
module bounds_checker (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic                    busy_i,
  input  wire logic [mipb_pkg::FW-1:0] seed_value_i,
  input  wire logic [mipb_pkg::FW-1:0] coefficient_i,
  input  wire logic [mipb_pkg::FW-1:0] range_low_i,
  input  wire logic [mipb_pkg::FW-1:0] range_high_i,
  input  wire logic                    cfg_we_i,
  input  wire logic [mipb_pkg::MW-1:0] cfg_wdata_i,
  input  wire logic                    done_i,
  input  wire logic [mipb_pkg::FW-1:0] bound_min_i,
  input  wire logic [mipb_pkg::FW-1:0] bound_max_i,
  input  wire logic                    seed_ok_i,
  output int                           errors_o,
  output int                           pending_o,
  output int                           results_o
);
  import mipb_pkg::*;

  typedef logic signed [127:0] wide_t;
  localparam int REFINE_CAP = 100;

  typedef struct {
    logic [FW-1:0] bmin;
    logic [FW-1:0] bmax;
    logic          ok;
  } bounds_t;

  bounds_t   bounds_q[$];
  wide_t     modulus;

  function automatic wide_t fdiv(wide_t n, wide_t d);
    wide_t an, ad, q, r;
    an = n < 0 ? -n : n;
    ad = d < 0 ? -d : d;
    if (ad == 0) begin
      q = 0;
      r = an;
    end else begin
      q = an / ad;
      r = an % ad;
    end
    if ((n < 0) != (d < 0)) begin
      q = -q;
      if (r != 0) q = q - 1;
    end
    return q;
  endfunction

  function automatic wide_t cdiv(wide_t n, wide_t d);
    return -fdiv(-n, d);
  endfunction

  function automatic wide_t md(wide_t n, wide_t m);
    return n - fdiv(n, m) * m;
  endfunction

  function automatic bit within_rng(wide_t x, wide_t lo, wide_t hi);
    return lo <= x && x <= hi;
  endfunction

  function automatic bit residue_ok(wide_t y, wide_t a, wide_t lo, wide_t hi, wide_t m);
    wide_t r;
    r = md(a * y, m);
    if (lo <= hi) return within_rng(r, lo, hi);
    return r <= hi || lo <= r;
  endfunction

  function automatic wide_t drift_right(wide_t y0, wide_t a, wide_t lo0, wide_t hi, wide_t m);
    wide_t lo, am, k, ay0, d0, yh0, ayh0, yl1, ayl1, d1, yh1, ayh1;
    wide_t stp, alpha, n, yhn, ayhn, ynx, aynx;
    lo = lo0 > hi ? lo0 - m : lo0;
    am = a - m;
    k = cdiv(lo - a * y0, m);
    ay0 = a * y0 + k * m;
    d0 = fdiv(hi - ay0, a);
    yh0 = y0 + d0;
    ayh0 = ay0 + a * d0;
    yl1 = yh0 + 1;
    ayl1 = ayh0 + am;
    if (!within_rng(ayl1, lo, hi)) return yh0;
    d1 = fdiv(hi - ayl1, a);
    yh1 = yl1 + d1;
    ayh1 = ayl1 + a * d1;
    if (!within_rng(ayh1 + am, lo, hi)) return yh1;
    stp = yh1 - yh0;
    alpha = a * stp - m;
    if (alpha == 0) return y0 + m;
    n = alpha < 0 ? fdiv(lo - ayl1, alpha) : fdiv(hi - ayh1, alpha);
    yhn = yh1 + n * stp;
    ayhn = ayh1 + n * alpha;
    ynx = yhn + 1;
    aynx = ayhn + am;
    if (within_rng(aynx, lo, hi)) return ynx + fdiv(hi - aynx, a);
    return yhn;
  endfunction

  function automatic wide_t neg_res(wide_t x, wide_t m);
    return x == 0 ? x : m - x;
  endfunction

  function automatic wide_t drift_left(wide_t y0, wide_t a, wide_t lo, wide_t hi, wide_t m);
    wide_t r;
    r = -drift_right(-y0, a, neg_res(hi, m), neg_res(lo, m), m);
    if (r > y0) r = r - cdiv(r - y0, m) * m;
    return r;
  endfunction

  function automatic bounds_t predict_bounds(logic [FW-1:0] ys, logic [FW-1:0] as,
                                             logic [FW-1:0] ls, logic [FW-1:0] hs,
                                             wide_t m);
    bounds_t res;
    wide_t   y0, a, lo, hi, mm1, ymax, ymin, lim;
    bit      full;
    int      n;
    y0 = md(wide_t'(ys), m);
    a = md(wide_t'(as), m);
    lo = md(wide_t'(ls), m);
    hi = md(wide_t'(hs), m);
    mm1 = m - 1;
    res.bmin = '0;
    res.bmax = '0;
    res.ok = 1'b0;
    if (!residue_ok(y0, a, lo, hi, m)) return res;
    res.ok = 1'b1;
    if (lo <= hi) full = lo == 0 && hi == mm1;
    else full = lo == hi + 1;
    if (full || a == 0) begin
      res.bmax = mm1[FW-1:0];
      return res;
    end
    lim = y0 + mm1;
    ymax = drift_right(y0, a, lo, hi, m);
    n = 0;
    while (ymax < lim && residue_ok(ymax + 1, a, lo, hi, m)) begin
      ymax = drift_right(ymax + 1, a, lo, hi, m);
      n++;
      if (n == REFINE_CAP) break;
    end
    lim = ymax - m + 1;
    ymin = y0;
    n = 0;
    while (ymin > lim && residue_ok(ymin - 1, a, lo, hi, m)) begin
      ymin = drift_left(ymin - 1, a, lo, hi, m);
      n++;
      if (n == REFINE_CAP) break;
    end
    if (ymax - ymin + 1 >= m) begin
      res.bmax = mm1[FW-1:0];
    end else begin
      res.bmin = md(ymin, m);
      res.bmax = md(ymax, m);
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [FW-1:0] got, logic [FW-1:0] want);
    $display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bounds_t want;
    if (!rst_ni) begin
      modulus <= wide_t'(1) << FW;
      bounds_q.delete();
      errors_o <= 0;
      pending_o <= 0;
      results_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_wdata_i < 2) modulus <= 2;
        else if (wide_t'(cfg_wdata_i) > (wide_t'(1) << FW)) modulus <= wide_t'(1) << FW;
        else modulus <= wide_t'(cfg_wdata_i);
      end
      if (start_i && !busy_i) begin
        bounds_q.push_back(predict_bounds(seed_value_i, coefficient_i, range_low_i,
                                          range_high_i, modulus));
      end
      if (done_i) begin
        results_o <= results_o + 1;
        if (bounds_q.size() == 0) begin
          report_mismatch("unexpected result word, bound_max", bound_max_i, '0);
        end else begin
          want = bounds_q.pop_front();
          if (seed_ok_i !== want.ok) report_mismatch("seed_ok", FW'(seed_ok_i), FW'(want.ok));
          if (bound_min_i !== want.bmin) report_mismatch("bound_min", bound_min_i, want.bmin);
          if (bound_max_i !== want.bmax) report_mismatch("bound_max", bound_max_i, want.bmax);
        end
      end
      pending_o <= bounds_q.size();
    end
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// Top of the bounds unit testbench: clock, reset, modulus settings, directed and random
// words in bursts, watchdog and verdict. Depends on mipb_pkg, the unit and bounds_checker.
module testbench;
  import mipb_pkg::*;

  localparam int IDLE_LIMIT = 4000000;
  localparam int WORDS_PER_PHASE = 44;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  logic [FW-1:0] seed_value, coefficient, range_low, range_high;
  logic          cfg_we;
  logic [MW-1:0] cfg_wdata;
  logic          done;
  logic [FW-1:0] bound_min, bound_max;
  logic          seed_ok;
  int            errors, pending, results;
  int            idle_cycles;
  int            words_sent;
  int            settings_used;
  longint unsigned cur_mod;

  modular_interval_preimage_bounds_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n), .start(start), .busy(busy),
    .seed_value_i(seed_value), .coefficient_i(coefficient),
    .range_low_i(range_low), .range_high_i(range_high),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .done_o(done), .bound_min_o(bound_min), .bound_max_o(bound_max), .seed_ok_o(seed_ok)
  );

  bounds_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_i(busy),
    .seed_value_i(seed_value), .coefficient_i(coefficient),
    .range_low_i(range_low), .range_high_i(range_high),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .done_i(done), .bound_min_i(bound_min), .bound_max_i(bound_max), .seed_ok_i(seed_ok),
    .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", idle_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_word(logic [FW-1:0] y, logic [FW-1:0] a, logic [FW-1:0] lo,
                           logic [FW-1:0] hi);
    seed_value <= y;
    coefficient <= a;
    range_low <= lo;
    range_high <= hi;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
  endtask

  task automatic pause_sender();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_modulus(logic [MW-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (value < 2) cur_mod = 2;
    else if (value > 34'h1_0000_0000) cur_mod = 64'h1_0000_0000;
    else cur_mod = 64'(value);
    settings_used++;
  endtask

  task automatic random_words(int count);
    int              burst;
    longint unsigned a, y, r, off_lo, off_hi, span;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        a = $urandom % cur_mod;
        if (a == 0) a = 1;
        y = $urandom % cur_mod;
        r = (a * y) % cur_mod;
        span = cur_mod >> $urandom_range(0, 32);
        off_lo = $urandom % (span + 1);
        off_hi = $urandom % (span + 1);
        send_word(FW'(y), FW'(a), FW'((r + cur_mod - (off_lo % cur_mod)) % cur_mod),
                  FW'((r + off_hi) % cur_mod));
      end else begin
        send_word($urandom, $urandom, $urandom, $urandom);
      end
      if (burst <= 0) begin
        burst = $urandom_range(1, 8);
        if ($urandom_range(0, 3) != 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end
      end
      burst--;
    end
  endtask

  initial begin
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    seed_value = '0;
    coefficient = '0;
    range_low = '0;
    range_high = '0;
    rst_n = 1'b0;
    idle_cycles = 0;
    words_sent = 0;
    settings_used = 1;
    cur_mod = 64'h1_0000_0000;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(32'd5, 32'd1, 32'd10, 32'd20);
    send_word(32'd12345, 32'd7, 32'd0, 32'hffff_ffff);
    pause_sender();
    send_word(32'd99, 32'd3, 32'h8000_0000, 32'h7fff_ffff);
    send_word(32'hffff_ffff, 32'hffff_ffff, 32'd0, 32'd0);
    send_word(32'hffff_ffff, 32'hffff_ffff, 32'd1, 32'd1);
    send_word(32'd0, 32'd3, 32'hffff_0000, 32'd100);
    send_word(32'd0, 32'd1, 32'd0, 32'd0);
    send_word(32'h1234_5678, 32'h8000_0001, 32'h1000_0000, 32'hf000_0000);
    random_words(WORDS_PER_PHASE);

    set_modulus(33'h1_ffff_ffff);
    random_words(WORDS_PER_PHASE);

    set_modulus(33'd37);
    send_word(32'd5, 32'd37, 32'd0, 32'd3);
    send_word(32'd5, 32'd74, 32'd2, 32'd9);
    send_word(32'hffff_ffff, 32'hffff_fff0, 32'hffff_fffe, 32'd40);
    send_word(32'd10, 32'd6, 32'd30, 32'd5);
    random_words(WORDS_PER_PHASE);

    set_modulus(33'd0);
    send_word(32'd1, 32'd1, 32'd1, 32'd1);
    send_word(32'd1, 32'd1, 32'd0, 32'd0);
    random_words(WORDS_PER_PHASE / 2);

    set_modulus(33'd1000003);
    random_words(WORDS_PER_PHASE);

    set_modulus(33'h0_ffff_fffb);
    random_words(WORDS_PER_PHASE);

    set_modulus(33'h1_0000_0000);
    random_words(WORDS_PER_PHASE);

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d words and checked %0d results under %0d modulus settings.",
             words_sent, results, settings_used);
    $display("Settings ran from the clamped minimum of 2 up to 2^32, plus three odd moduli.");
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
